// ----- rtl/core/fcr_pkg.sv -----
// fcr_pkg: shared types and constants for the framed command receiver.
// Used by the channel interfaces and every module in rtl/core.
package fcr_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [1:0]  status_t;
  typedef logic [2:0]  mode_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SYNC_WORD = 1'b0;
  localparam cfg_idx_t REG_TAIL_WORD = 1'b1;

  localparam word_t SYNC_WORD_RST = 16'h1234;
  localparam word_t TAIL_WORD_RST = 16'h1F2F;

  // Frame status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_TAIL  = 2'd1;
  localparam status_t ST_BAD_SUM   = 2'd2;
  localparam status_t ST_BAD_LEN   = 2'd3;

  // Mode machine codes
  localparam mode_t MODE_WAITING   = 3'd0;
  localparam mode_t MODE_WASHING   = 3'd1;
  localparam mode_t MODE_WAIT_LOAD = 3'd2;
  localparam mode_t MODE_PAYING    = 3'd3;
  localparam mode_t MODE_DEBUG     = 3'd4;
  localparam mode_t MODE_WORKING   = 3'd5;

  // Commands
  localparam byte_t CMD_WASH      = 8'h01;
  localparam byte_t CMD_WAIT_LOAD = 8'h02;
  localparam byte_t CMD_PAY       = 8'h03;
  localparam byte_t CMD_DEBUG     = 8'h04;
  localparam byte_t CMD_PAY_DONE  = 8'h20;
  localparam byte_t CMD_PAY_WORK  = 8'h21;
  localparam byte_t CMD_DBG_WORK  = 8'h06;

  // Frame layout
  localparam byte_t MIN_FRAME_LEN = 8'd4;
  localparam byte_t SUM_FRAME_LEN = 8'd6;
  localparam byte_t LEN5_FRAME    = 8'd5;
  localparam byte_t POS_LENGTH    = 8'd2;
  localparam byte_t POS_COMMAND   = 8'd3;
  localparam byte_t POS_PARAM1    = 8'd4;
  localparam byte_t POS_PARAM2    = 8'd5;

  // End-of-frame event from the parser
  typedef struct packed {
    logic    done;
    logic    good;
    status_t status;
    byte_t   command;
    byte_t   param_first;
    byte_t   param_second;
  } evt_t;

  // Mode machine outcome for one event
  typedef struct packed {
    mode_t mode;
    logic  changed;
  } mode_res_t;

endpackage

// ----- rtl/core/fcr_if.sv -----
// Channel interfaces: received byte words in, frame result words out.
// Depends on fcr_pkg for field types.
interface fcr_in_if;
  logic           valid;
  logic           ready;
  fcr_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcr_out_if;
  logic             valid;
  logic             ready;
  fcr_pkg::status_t frame_status;
  fcr_pkg::byte_t   command;
  fcr_pkg::byte_t   param_first;
  fcr_pkg::byte_t   param_second;
  fcr_pkg::mode_t   mode;
  logic             mode_changed;

  modport source (output valid, output frame_status, output command, output param_first,
                  output param_second, output mode, output mode_changed, input ready);
  modport sink   (input valid, input frame_status, input command, input param_first,
                  input param_second, input mode, input mode_changed, output ready);
endinterface

// ----- rtl/core/fcr_parser.sv -----
// fcr_parser: sync hunt, length capture, running checksum and tail check.
// Depends on fcr_pkg. Produces one end-of-frame event per finished frame.
module fcr_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  fcr_pkg::byte_t  rx_byte,
  input  fcr_pkg::word_t  sync_word,
  input  fcr_pkg::word_t  tail_word,
  output fcr_pkg::evt_t   evt
);

  fcr_pkg::word_t hdr_r,   hdr_nxt;
  fcr_pkg::byte_t pos_r,   pos_nxt;
  fcr_pkg::byte_t len_r,   len_nxt;
  fcr_pkg::word_t sum_r,   sum_nxt;
  fcr_pkg::byte_t chk_r,   chk_nxt;
  fcr_pkg::byte_t cmd_r,   cmd_nxt;
  fcr_pkg::byte_t p1_r,    p1_nxt;
  fcr_pkg::byte_t p2_r,    p2_nxt;
  fcr_pkg::word_t tail_r,  tail_nxt;

  logic [8:0] pos_ext;
  logic [8:0] len_ext;

  assign pos_ext = {1'b0, pos_r};
  assign len_ext = {1'b0, len_r};

  // Next-state and end-of-frame decode for the accepted byte
  always_comb begin
    hdr_nxt  = hdr_r;
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    chk_nxt  = chk_r;
    cmd_nxt  = cmd_r;
    p1_nxt   = p1_r;
    p2_nxt   = p2_r;
    tail_nxt = tail_r;
    evt      = '0;

    if (acc) begin
      if (pos_r < fcr_pkg::POS_LENGTH) begin
        // filling the header window
        hdr_nxt = {hdr_r[7:0], rx_byte};
        pos_nxt = pos_r + 8'd1;
      end else if (pos_r == fcr_pkg::POS_LENGTH) begin
        if (hdr_r != sync_word) begin
          hdr_nxt = {hdr_r[7:0], rx_byte};
        end else if (rx_byte < fcr_pkg::MIN_FRAME_LEN) begin
          // short length: report and start over
          evt.done   = 1'b1;
          evt.status = fcr_pkg::ST_BAD_LEN;
          hdr_nxt  = '0;
          pos_nxt  = '0;
          len_nxt  = '0;
          sum_nxt  = '0;
          chk_nxt  = '0;
          cmd_nxt  = '0;
          p1_nxt   = '0;
          p2_nxt   = '0;
          tail_nxt = '0;
        end else begin
          len_nxt  = rx_byte;
          cmd_nxt  = '0;
          p1_nxt   = '0;
          p2_nxt   = '0;
          tail_nxt = {hdr_r[7:0], rx_byte};
          // length byte is summed only when the sum range reaches it
          sum_nxt  = (rx_byte >= fcr_pkg::SUM_FRAME_LEN) ? {8'd0, rx_byte} : '0;
          if (rx_byte == fcr_pkg::MIN_FRAME_LEN) begin
            chk_nxt = hdr_r[7:0];
          end else if (rx_byte == fcr_pkg::LEN5_FRAME) begin
            chk_nxt = rx_byte;
          end else begin
            chk_nxt = '0;
          end
          pos_nxt = fcr_pkg::POS_COMMAND;
        end
      end else begin
        // inside a frame
        if (pos_r == fcr_pkg::POS_COMMAND) cmd_nxt = rx_byte;
        if (pos_r == fcr_pkg::POS_PARAM1)  p1_nxt  = rx_byte;
        if (pos_r == fcr_pkg::POS_PARAM2)  p2_nxt  = rx_byte;
        if (pos_ext + 9'd4 <= len_ext) sum_nxt = sum_r + {8'd0, rx_byte};
        if (pos_ext + 9'd3 == len_ext) chk_nxt = rx_byte;
        tail_nxt = {tail_r[7:0], rx_byte};
        pos_nxt  = pos_r + 8'd1;

        if (pos_ext + 9'd1 >= len_ext) begin
          evt.done         = 1'b1;
          evt.command      = cmd_nxt;
          evt.param_first  = p1_nxt;
          evt.param_second = p2_nxt;
          priority if (tail_nxt != tail_word) begin
            evt.status = fcr_pkg::ST_BAD_TAIL;
          end else if (sum_nxt != {8'd0, chk_nxt}) begin
            evt.status = fcr_pkg::ST_BAD_SUM;
          end else begin
            evt.status = fcr_pkg::ST_OK;
            evt.good   = 1'b1;
          end
          hdr_nxt  = '0;
          pos_nxt  = '0;
          len_nxt  = '0;
          sum_nxt  = '0;
          chk_nxt  = '0;
          cmd_nxt  = '0;
          p1_nxt   = '0;
          p2_nxt   = '0;
          tail_nxt = '0;
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= '0;
      pos_r  <= '0;
      len_r  <= '0;
      sum_r  <= '0;
      chk_r  <= '0;
      cmd_r  <= '0;
      p1_r   <= '0;
      p2_r   <= '0;
      tail_r <= '0;
    end else begin
      hdr_r  <= hdr_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      chk_r  <= chk_nxt;
      cmd_r  <= cmd_nxt;
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      tail_r <= tail_nxt;
    end
  end

endmodule

// ----- rtl/core/fcr_mode_fsm.sv -----
// fcr_mode_fsm: six-state mode machine stepped by the command of a good frame.
// Depends on fcr_pkg.
module fcr_mode_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  fcr_pkg::evt_t       evt,
  output fcr_pkg::mode_res_t  res
);

  fcr_pkg::mode_t mode_r, mode_nxt;
  logic           step;
  logic           changed;

  // Transition decode, taken only on a good frame
  always_comb begin
    step     = evt.done && evt.good;
    mode_nxt = mode_r;
    changed  = 1'b0;
    if (step) begin
      unique case (mode_r)
        fcr_pkg::MODE_WAITING: begin
          if (evt.command == fcr_pkg::CMD_WASH) begin
            mode_nxt = fcr_pkg::MODE_WASHING;
            changed  = 1'b1;
          end else if (evt.command == fcr_pkg::CMD_WAIT_LOAD) begin
            mode_nxt = fcr_pkg::MODE_WAIT_LOAD;
            changed  = 1'b1;
          end else if (evt.command == fcr_pkg::CMD_PAY) begin
            mode_nxt = fcr_pkg::MODE_PAYING;
            changed  = 1'b1;
          end else if (evt.command == fcr_pkg::CMD_DEBUG) begin
            mode_nxt = fcr_pkg::MODE_DEBUG;
            changed  = 1'b1;
          end
        end
        fcr_pkg::MODE_PAYING: begin
          if (evt.command == fcr_pkg::CMD_PAY_DONE) begin
            mode_nxt = fcr_pkg::MODE_WAITING;
            changed  = 1'b1;
          end else if (evt.command == fcr_pkg::CMD_PAY_WORK) begin
            mode_nxt = fcr_pkg::MODE_WORKING;
            changed  = 1'b1;
          end
        end
        fcr_pkg::MODE_DEBUG: begin
          if (evt.command == fcr_pkg::CMD_DBG_WORK) begin
            mode_nxt = fcr_pkg::MODE_WORKING;
            changed  = 1'b1;
          end
        end
        default: begin
          // washing, wait load, working: any command returns to waiting
          mode_nxt = fcr_pkg::MODE_WAITING;
          changed  = 1'b1;
        end
      endcase
    end
  end

  assign res.mode    = mode_nxt;
  assign res.changed = changed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fcr_pkg::MODE_WAITING;
    end else begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ----- rtl/core/fcr_out_reg.sv -----
// fcr_out_reg: result register driving the output channel.
// Depends on fcr_pkg and fcr_out_if. Takes a new word while the old one drains.
module fcr_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  fcr_pkg::evt_t       evt,
  input  fcr_pkg::mode_res_t  mres,
  output logic                can_take,
  fcr_out_if.source           out_ch
);

  logic               valid_r;
  fcr_pkg::evt_t      evt_r;
  fcr_pkg::mode_res_t mres_r;
  logic               load;

  // room when empty or when the held word leaves this cycle
  assign can_take = !valid_r || out_ch.ready;
  assign load     = acc && evt.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      evt_r  <= evt;
      mres_r <= mres;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.frame_status = evt_r.status;
  assign out_ch.command      = evt_r.command;
  assign out_ch.param_first  = evt_r.param_first;
  assign out_ch.param_second = evt_r.param_second;
  assign out_ch.mode         = mres_r.mode;
  assign out_ch.mode_changed = mres_r.changed;

endmodule

// ----- rtl/core/framed_command_receiver.sv -----
// framed_command_receiver: top level of the framed command receiver.
// Depends on fcr_pkg, fcr_if, fcr_parser, fcr_mode_fsm and fcr_out_reg.
//
//   channel   dir   handshake       payload
//   in_ch     in    valid/ready     rx_byte[7:0]
//   out_ch    out   valid/ready     frame_status, command, param_first/second, mode, mode_changed
//   cfg_*     in    cfg_we          cfg_index (0 sync_word, 1 tail_word), cfg_data[15:0]
//
// One received byte per cycle while in_ch.ready is high: parser and mode machine update at the accept edge,
// and a finished frame's result appears in the output register on the next cycle.
// in_ch.ready is high whenever the output register is empty or is being drained.
// Reset (rst_n low, synchronous) clears the parser, sets the mode to waiting and
// loads the sync and tail words with their defaults.
module framed_command_receiver (
  input  logic              clk,
  input  logic              rst_n,
  fcr_in_if.sink            in_ch,
  fcr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  fcr_pkg::cfg_idx_t cfg_index,
  input  fcr_pkg::word_t    cfg_data
);

  fcr_pkg::word_t     sync_word_r;
  fcr_pkg::word_t     tail_word_r;
  fcr_pkg::evt_t      evt;
  fcr_pkg::mode_res_t mres;
  logic               can_take;
  logic               acc;

  assign in_ch.ready = can_take;
  assign acc         = in_ch.valid && can_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= fcr_pkg::SYNC_WORD_RST;
      tail_word_r <= fcr_pkg::TAIL_WORD_RST;
    end else if (cfg_we) begin
      if (cfg_index == fcr_pkg::REG_SYNC_WORD) begin
        sync_word_r <= cfg_data;
      end else begin
        tail_word_r <= cfg_data;
      end
    end
  end

  fcr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_ch.rx_byte),
    .sync_word (sync_word_r),
    .tail_word (tail_word_r),
    .evt       (evt)
  );

  fcr_mode_fsm u_mode (
    .clk   (clk),
    .rst_n (rst_n),
    .evt   (evt),
    .res   (mres)
  );

  fcr_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .evt      (evt),
    .mres     (mres),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

endmodule
